// File: rtl/core/scd_pkg.sv
// Package: item types, division constants and month tables for the calendar converter.
`timescale 1ns / 1ps
package scd_pkg;

    typedef struct packed {
        logic [31:0] epoch_seconds;
    } t_in_item;

    typedef struct packed {
        logic [7:0] year_offset;
        logic [3:0] month_number;
        logic [4:0] day_of_month;
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
        logic [5:0] second_of_minute;
        logic [2:0] day_of_week;
    } t_out_item;

    localparam int unsigned NUM_STAGES = 7;

    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [10:0] DAYS_PER_BLK = 11'd1461;
    localparam logic [8:0]  DAYS_LEAP    = 9'd366;
    localparam logic [9:0]  DAYS_Y2      = 10'd731;
    localparam logic [10:0] DAYS_Y3      = 11'd1096;
    localparam logic [15:0] WEEK_BIAS    = 16'd6;

    // Reciprocals: q = (x * M) >> K, exact over each operand's range
    localparam logic [25:0] RCP_DAY      = 26'd50903317;  // (s >> 7) / 675, K = 35
    localparam int unsigned SH_DAY       = 35;
    localparam logic [16:0] RCP_BLK      = 17'd91868;     // days / 1461, K = 27
    localparam int unsigned SH_BLK       = 27;
    localparam logic [17:0] RCP_WEEK     = 18'd149797;    // x / 7, K = 20
    localparam int unsigned SH_WEEK      = 20;
    localparam logic [13:0] RCP_HOUR     = 14'd9321;      // (tod >> 4) / 225, K = 21
    localparam int unsigned SH_HOUR      = 21;
    localparam logic [10:0] RCP_MIN      = 11'd1093;      // (sec >> 2) / 15, K = 14
    localparam int unsigned SH_MIN       = 14;

    function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (idx >= 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// File: rtl/core/scd_if.sv
// Interfaces: input and result item channels with valid/ready handshake.
`timescale 1ns / 1ps
interface scd_in_if;
    logic               valid;
    logic               ready;
    scd_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface scd_out_if;
    logic               valid;
    logic               ready;
    scd_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/seconds_to_calendar_datetime.sv
// Top level: pipelined conversion of epoch seconds to calendar date, time and weekday.
//
//  Channel   Dir   Payload                                   Handshake
//  i_sec     in    epoch_seconds (32b)                       valid/ready
//  o_cal     out   year, month, day, hour, min, sec, wday    valid/ready
//
//  Seven register stages; o_cal.valid is the valid bit of the last stage.
//  One item accepted per cycle while o_cal is ready or a stage is empty; each
//  stage is at most one constant multiply deep between registers.
//  Each stage loads when empty or when the next one loads, so bubbles fill
//  while o_cal stalls. Synchronous active-low reset clears the valid bits only.
`timescale 1ns / 1ps
module seconds_to_calendar_datetime (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scd_in_if.sink      i_sec,
    scd_out_if.source   o_cal
);
    import scd_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] ld;

    // stage 0
    logic [31:0] r_s0_sec;
    // stage 1
    logic [31:0] r_s1_sec;
    logic [15:0] r_s1_days;
    // stage 2
    logic [15:0] r_s2_days;
    logic [16:0] r_s2_tod;
    logic [5:0]  r_s2_blk;
    logic [16:0] r_s2_wsum;
    logic [14:0] r_s2_wq;
    // stage 3
    logic [10:0] r_s3_rdays;
    logic [5:0]  r_s3_blk;
    logic [16:0] r_s3_tod;
    logic [4:0]  r_s3_hour;
    logic [2:0]  r_s3_wday;
    // stage 4
    logic [7:0]  r_s4_year;
    logic        r_s4_leap;
    logic [8:0]  r_s4_doy;
    logic [4:0]  r_s4_hour;
    logic [11:0] r_s4_msec;
    logic [2:0]  r_s4_wday;
    // stage 5
    logic [7:0]  r_s5_year;
    logic [3:0]  r_s5_month;
    logic [4:0]  r_s5_day;
    logic [4:0]  r_s5_hour;
    logic [5:0]  r_s5_min;
    logic [11:0] r_s5_msec;
    logic [2:0]  r_s5_wday;
    // stage 6
    t_out_item   r_out;

    logic [50:0] day_prod;
    logic [32:0] blk_prod;
    logic [34:0] week_prod;
    logic [31:0] day_secs;
    logic [26:0] hour_prod;
    logic [20:0] min_prod;
    logic [15:0] blk_days;
    logic [16:0] wk_mul;
    logic [16:0] hour_secs;
    logic [1:0]  yin;
    logic [10:0] ystart;
    logic [10:0] doy_full;
    logic [3:0]  month;
    logic [8:0]  mbase;
    logic [8:0]  day_full;
    logic [11:0] min_secs;
    logic [11:0] sec_full;

    // Advance chain
    always_comb begin
        ld[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_cal.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
        n_vld = r_vld;
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (ld[k]) begin
                n_vld[k] = (k == 0) ? i_sec.valid : r_vld[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign i_sec.ready   = ld[0];
    assign o_cal.valid   = r_vld[NUM_STAGES-1];
    assign o_cal.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Datapath
    always_comb begin
        day_prod  = {26'd0, r_s0_sec[31:7]} * {25'd0, RCP_DAY};
        day_secs  = {16'd0, r_s1_days} * {15'd0, SEC_PER_DAY};
        blk_prod  = {17'd0, r_s1_days} * {16'd0, RCP_BLK};
        week_prod = {19'd0, r_s1_days + WEEK_BIAS} * {17'd0, RCP_WEEK};

        blk_days  = {10'd0, r_s2_blk} * {5'd0, DAYS_PER_BLK};
        wk_mul    = {r_s2_wq, 2'b00} + {1'b0, r_s2_wq, 1'b0} + {2'd0, r_s2_wq};
        hour_prod = {14'd0, r_s2_tod[16:4]} * {13'd0, RCP_HOUR};

        hour_secs = {12'd0, r_s3_hour} * {5'd0, SEC_PER_HOUR};
        if (r_s3_rdays >= DAYS_Y3) begin
            yin    = 2'd3;
            ystart = DAYS_Y3;
        end else if (r_s3_rdays >= {1'b0, DAYS_Y2}) begin
            yin    = 2'd2;
            ystart = {1'b0, DAYS_Y2};
        end else if (r_s3_rdays >= {2'b0, DAYS_LEAP}) begin
            yin    = 2'd1;
            ystart = {2'b0, DAYS_LEAP};
        end else begin
            yin    = 2'd0;
            ystart = 11'd0;
        end
        doy_full = r_s3_rdays - ystart;

        month = 4'd1;
        mbase = 9'd0;
        for (int k = 1; k < 12; k++) begin
            if (r_s4_doy >= cum_days(r_s4_leap, 4'(k))) begin
                month = 4'(k + 1);
                mbase = cum_days(r_s4_leap, 4'(k));
            end
        end
        day_full = r_s4_doy - mbase + 9'd1;
        min_prod = {11'd0, r_s4_msec[11:2]} * {10'd0, RCP_MIN};

        min_secs = {6'd0, r_s5_min} * {6'd0, SEC_PER_MIN};
        sec_full = r_s5_msec - min_secs;
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_s0_sec <= i_sec.payload.epoch_seconds;
        end
        if (ld[1]) begin
            r_s1_sec  <= r_s0_sec;
            r_s1_days <= day_prod[SH_DAY+15:SH_DAY];
        end
        if (ld[2]) begin
            r_s2_days <= r_s1_days;
            r_s2_tod  <= 17'(r_s1_sec - day_secs);
            r_s2_blk  <= blk_prod[SH_BLK+5:SH_BLK];
            r_s2_wsum <= {1'b0, r_s1_days} + {1'b0, WEEK_BIAS};
            r_s2_wq   <= week_prod[SH_WEEK+14:SH_WEEK];
        end
        if (ld[3]) begin
            r_s3_rdays <= 11'(r_s2_days - blk_days);
            r_s3_blk   <= r_s2_blk;
            r_s3_tod   <= r_s2_tod;
            r_s3_hour  <= hour_prod[SH_HOUR+4:SH_HOUR];
            r_s3_wday  <= 3'(r_s2_wsum - wk_mul);
        end
        if (ld[4]) begin
            r_s4_year <= {r_s3_blk, yin};
            r_s4_leap <= (yin == 2'd0);
            r_s4_doy  <= doy_full[8:0];
            r_s4_hour <= r_s3_hour;
            r_s4_msec <= 12'(r_s3_tod - hour_secs);
            r_s4_wday <= r_s3_wday;
        end
        if (ld[5]) begin
            r_s5_year  <= r_s4_year;
            r_s5_month <= month;
            r_s5_day   <= day_full[4:0];
            r_s5_hour  <= r_s4_hour;
            r_s5_min   <= min_prod[SH_MIN+5:SH_MIN];
            r_s5_msec  <= r_s4_msec;
            r_s5_wday  <= r_s4_wday;
        end
        if (ld[6]) begin
            r_out.year_offset      <= r_s5_year;
            r_out.month_number     <= r_s5_month;
            r_out.day_of_month     <= r_s5_day;
            r_out.hour_of_day      <= r_s5_hour;
            r_out.minute_of_hour   <= r_s5_min;
            r_out.second_of_minute <= sec_full[5:0];
            r_out.day_of_week      <= r_s5_wday;
        end
    end

endmodule

// File: dv/seconds_to_calendar_datetime_tb.sv
// Testbench: random and directed epoch seconds, checked against a calendar predictor.
`timescale 1ns / 1ps
module seconds_to_calendar_datetime_tb;
    import scd_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1075;
    localparam int unsigned HOLD_CYCLES  = 64;
    localparam int unsigned HOLD_AFTER   = 300;
    localparam int unsigned IDLE_LIMIT   = 1000;
    localparam int unsigned MAX_PRINTS   = 40;

    localparam int unsigned YEAR_START_DAYS [4]  = '{0, 366, 731, 1096};
    localparam int unsigned CUM_COMMON      [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243,
                                                    273, 304, 334};
    localparam int unsigned CUM_LEAP        [12] = '{0, 31, 60, 91, 121, 152, 182, 213, 244,
                                                    274, 305, 335};

    class calendar_scoreboard;
        typedef struct {
            logic [31:0] secs;
            t_out_item   cal;
        } t_expected;

        t_expected   expected_q[$];
        int unsigned n_errors;

        function t_out_item convert(logic [31:0] secs);
            int unsigned days;
            int unsigned tod;
            int unsigned day_in_blk;
            int unsigned yin;
            int unsigned doy;
            int unsigned month;
            int unsigned month_base;
            logic        leap;
            t_out_item   cal;
            days       = secs / 32'd86400;
            tod        = secs % 32'd86400;
            day_in_blk = days % 32'd1461;
            yin        = 0;
            for (int k = 1; k < 4; k++) begin
                if (day_in_blk >= YEAR_START_DAYS[k]) begin
                    yin = k;
                end
            end
            doy   = day_in_blk - YEAR_START_DAYS[yin];
            leap  = (yin == 0);
            month = 1;
            for (int k = 1; k < 12; k++) begin
                if (doy >= (leap ? CUM_LEAP[k] : CUM_COMMON[k])) begin
                    month = k + 1;
                end
            end
            month_base           = leap ? CUM_LEAP[month - 1] : CUM_COMMON[month - 1];
            cal.year_offset      = 8'((days / 32'd1461) * 4 + yin);
            cal.month_number     = 4'(month);
            cal.day_of_month     = 5'(doy - month_base + 1);
            cal.hour_of_day      = 5'(tod / 32'd3600);
            cal.minute_of_hour   = 6'((tod % 32'd3600) / 32'd60);
            cal.second_of_minute = 6'(tod % 32'd60);
            cal.day_of_week      = 3'((days + 6) % 32'd7);
            return cal;
        endfunction

        task report(string msg);
            if (n_errors < MAX_PRINTS) begin
                $display("[%0t] ERROR: %s", $realtime, msg);
            end
            n_errors++;
        endtask

        task check_field(string name, logic [31:0] secs, logic [31:0] got, logic [31:0] exp);
            if (got !== exp) begin
                report($sformatf("secs=%0d %s got %0d expected %0d", secs, name, got, exp));
            end
        endtask

        function void note_seconds(logic [31:0] secs);
            t_expected e;
            e.secs = secs;
            e.cal  = convert(secs);
            expected_q.push_back(e);
        endfunction

        task check_result(t_out_item got);
            t_expected e;
            if (expected_q.size() == 0) begin
                report($sformatf("result with no item pending: %h", got));
            end else begin
                e = expected_q.pop_front();
                check_field("year_offset", e.secs, got.year_offset, e.cal.year_offset);
                check_field("month_number", e.secs, got.month_number, e.cal.month_number);
                check_field("day_of_month", e.secs, got.day_of_month, e.cal.day_of_month);
                check_field("hour_of_day", e.secs, got.hour_of_day, e.cal.hour_of_day);
                check_field("minute_of_hour", e.secs, got.minute_of_hour,
                            e.cal.minute_of_hour);
                check_field("second_of_minute", e.secs, got.second_of_minute,
                            e.cal.second_of_minute);
                check_field("day_of_week", e.secs, got.day_of_week, e.cal.day_of_week);
            end
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    scd_in_if  sec_ch ();
    scd_out_if cal_ch ();

    calendar_scoreboard cal_sb = new();

    int unsigned n_accepted;
    int unsigned idle_cycles;
    int unsigned burst_left;

    seconds_to_calendar_datetime u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sec   (sec_ch),
        .o_cal   (cal_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && sec_ch.valid && sec_ch.ready) begin
            cal_sb.note_seconds(sec_ch.payload.epoch_seconds);
            n_accepted <= n_accepted + 1;
        end
        if (i_rst_n && cal_ch.valid && cal_ch.ready) begin
            cal_sb.check_result(cal_ch.payload);
        end
    end

    always @(posedge i_clk) begin
        if ((sec_ch.valid && sec_ch.ready) || (cal_ch.valid && cal_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("seconds_to_calendar_datetime_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall pattern, one long hold-off to back up the pipeline
    initial begin
        int unsigned run_len;
        int unsigned stall_len;
        bit          held;
        held         = 1'b0;
        cal_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && n_accepted >= HOLD_AFTER) begin
                held = 1'b1;
                cal_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                run_len   = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 16);
                stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                cal_ch.ready <= 1'b1;
                repeat (run_len) @(posedge i_clk);
                if (stall_len > 0) begin
                    cal_ch.ready <= 1'b0;
                    repeat (stall_len) @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_seconds(input logic [31:0] secs);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                sec_ch.valid <= 1'b0;
                sec_ch.payload.epoch_seconds <= $urandom;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        sec_ch.valid <= 1'b1;
        sec_ch.payload.epoch_seconds <= secs;
        do @(posedge i_clk); while (!sec_ch.ready);
    endtask

    function automatic logic [31:0] pick_seconds();
        int unsigned kind;
        int unsigned yin;
        int unsigned mon;
        longint      day;
        longint      secs;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            secs = longint'($urandom);
        end else if (kind < 50) begin
            day = longint'($urandom_range(0, 49710));
            case ($urandom_range(0, 3))
                0:       secs = day * 86400;
                1:       secs = day * 86400 + 86399;
                2:       secs = day * 86400 + 1;
                default: secs = day * 86400 + longint'($urandom_range(0, 86399));
            endcase
        end else if (kind < 85) begin
            yin  = $urandom_range(0, 3);
            mon  = $urandom_range(0, 11);
            day  = longint'($urandom_range(0, 34)) * 1461 + longint'(YEAR_START_DAYS[yin])
                 + longint'((yin == 0) ? CUM_LEAP[mon] : CUM_COMMON[mon])
                 - longint'($urandom_range(0, 1));
            secs = day * 86400 + longint'($urandom_range(0, 86399));
        end else begin
            secs = 64'hFFFF_FFFF - longint'($urandom_range(0, 200000000));
        end
        if (secs < 0 || secs > 64'hFFFF_FFFF) begin
            secs = longint'($urandom);
        end
        return secs[31:0];
    endfunction

    initial begin
        logic [31:0] directed_secs [$];
        directed_secs = '{
            32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
            32'd216000, 32'd302400, 32'd388800, 32'd475200, 32'd561600,
            32'd59 * 32'd86400 + 32'd45296,
            32'd60 * 32'd86400,
            32'd366 * 32'd86400 - 32'd1,
            32'd366 * 32'd86400,
            32'd425 * 32'd86400 - 32'd1,
            32'd425 * 32'd86400,
            32'd1461 * 32'd86400 - 32'd1,
            32'd1461 * 32'd86400,
            32'd36584 * 32'd86400 + 32'd1,
            32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555
        };
        i_rst_n      = 1'b0;
        n_accepted   = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        sec_ch.valid <= 1'b0;
        sec_ch.payload.epoch_seconds <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_secs[i]) begin
            send_seconds(directed_secs[i]);
        end
        repeat (RANDOM_ITEMS) begin
            send_seconds(pick_seconds());
        end
        sec_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (cal_sb.pending() != 0) @(posedge i_clk);
        repeat (NUM_STAGES + 4) @(posedge i_clk);

        if (cal_sb.n_errors == 0 && cal_sb.pending() == 0) begin
            $display("seconds_to_calendar_datetime_tb OK");
        end else begin
            $display("seconds_to_calendar_datetime_tb NOT OK");
        end
        $finish;
    end

endmodule
